// ===== design/bnhs_pkg.sv =====
// ----------------------------------------------------------------------------
// bnhs_pkg
// Shared codes and types for the bounded navigation history stack unit.
// ----------------------------------------------------------------------------
package bnhs_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UP       = 3'd0,
    ACT_DOWN     = 3'd1,
    ACT_REPL_CUR = 3'd2,
    ACT_REPL_ALL = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_POPPED   = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_FETCH
  } fsm_t;

endpackage

// ===== design/bnhs_ram.sv =====
// ----------------------------------------------------------------------------
// bnhs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bnhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bounded_navigation_history_stack_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_navigation_history_stack_unit
// Bounded stack of location keys driven by up, down and replace commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done high, and must be taken then.
// For most commands the result shows in the cycle after the command, and
// a new command may be issued in that same cycle. A pop that leaves two
// or more entries holds busy high in the FETCH state while the new up
// entry is read from the registered read port of the history memory.
// The two newest entries are held in registers; the history lives in a
// circular memory whose oldest slot is advanced when a push overflows.
// ----------------------------------------------------------------------------
module bounded_navigation_history_stack_unit #(
  parameter int HISTORY_DEPTH = 16,
  parameter int KEY_BITS      = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bnhs_pkg::ACTION_W-1:0]       action,
  input  logic [KEY_BITS-1:0]                 key,
  output logic                                done,
  output logic [bnhs_pkg::STATUS_W-1:0]       status,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0]  depth_now,
  output logic                                up_valid,
  output logic [KEY_BITS-1:0]                 up_key
);

  import bnhs_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] TWO  = CW'(2);
  localparam logic [CW-1:0] ONE  = CW'(1);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [AW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= (AW+1)'(HISTORY_DEPTH)) begin
      s = s - (AW+1)'(HISTORY_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fsm_t                state, state_next;
  logic [CW-1:0]       fill, fill_next;
  logic [AW-1:0]       base, base_next;
  logic [KEY_BITS-1:0] top, top_next;
  logic [KEY_BITS-1:0] second, second_next;

  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [KEY_BITS-1:0] rdata;

  logic                emit;
  status_t             res_status;
  logic [CW-1:0]       res_depth;
  logic                res_up_valid;
  logic [KEY_BITS-1:0] res_up_key;

  bnhs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      fill  <= '0;
      base  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      base  <= base_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    top    <= top_next;
    second <= second_next;
    if (emit) begin
      status    <= res_status;
      depth_now <= res_depth;
      up_valid  <= res_up_valid;
      up_key    <= res_up_key;
    end
  end

  always_comb begin
    logic [ACTION_W-1:0] act;
    logic                do_push;
    logic                do_pop;
    logic [CW-1:0]       f;

    state_next  = state;
    fill_next   = fill;
    base_next   = base;
    top_next    = top;
    second_next = second;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = slot(base, fill[AW-1:0]);
    raddr       = slot(base, AW'(fill - CW'(3)));
    emit        = 1'b0;
    res_status  = ST_DONE;
    busy        = (state == FSM_FETCH);
    do_push     = 1'b0;
    do_pop      = 1'b0;
    f           = fill;
    act         = action;

    case (state)
      FSM_IDLE: begin
        if (start) begin
          emit = 1'b1;
          if (act == ACT_UP && fill < TWO) begin
            act = ACT_REPL_ALL;
          end
          case (act)
            ACT_UP: begin
              if (key != second) begin
                res_status = ST_REJECTED;
              end else begin
                do_pop = 1'b1;
              end
            end
            ACT_DOWN: begin
              if (!(fill != '0 && key == top)) begin
                do_push = 1'b1;
              end
            end
            ACT_REPL_CUR: begin
              if (fill == '0) begin
                do_push = 1'b1;
              end else if (fill >= TWO && key == second) begin
                do_pop = 1'b1;
              end else begin
                we       = 1'b1;
                waddr    = slot(base, AW'(fill - ONE));
                top_next = key;
              end
            end
            ACT_REPL_ALL: begin
              f       = '0;
              do_push = 1'b1;
            end
            ACT_CLEAR: begin
              fill_next = '0;
            end
            default: begin
              res_status = ST_REJECTED;
            end
          endcase

          if (do_pop) begin
            res_status = ST_POPPED;
            fill_next  = fill - ONE;
            top_next   = second;
            if (fill > TWO) begin
              re         = 1'b1;
              emit       = 1'b0;
              state_next = FSM_FETCH;
            end
          end

          if (do_push) begin
            we          = 1'b1;
            second_next = top;
            top_next    = key;
            if (f == FULL) begin
              waddr     = base;
              base_next = (base == AW'(HISTORY_DEPTH - 1)) ? '0 : base + AW'(1);
              fill_next = f;
            end else begin
              waddr     = slot(base, f[AW-1:0]);
              fill_next = f + ONE;
            end
          end
        end
      end
      FSM_FETCH: begin
        second_next = rdata;
        emit        = 1'b1;
        res_status  = ST_POPPED;
        state_next  = FSM_IDLE;
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase

    res_depth    = fill_next;
    res_up_valid = (fill_next >= TWO);
    res_up_key   = res_up_valid ? second_next : '0;
  end

endmodule

// ===== design/bnhs_chk.sv =====
// ----------------------------------------------------------------------------
// bnhs_chk
// Port-level checks for the bounded navigation history stack unit.
// ----------------------------------------------------------------------------
module bnhs_chk #(
  parameter int HISTORY_DEPTH = 16,
  parameter int KEY_BITS      = 32
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [bnhs_pkg::STATUS_W-1:0]      status,
  input logic [$clog2(HISTORY_DEPTH+1)-1:0] depth_now,
  input logic                               up_valid,
  input logic [KEY_BITS-1:0]                up_key
);

  import bnhs_pkg::*;

  a_up_valid_depth: assert property (@(posedge clk) disable iff (rst)
    done |-> (up_valid == (depth_now >= 2)))
    else $error("up_valid disagrees with depth");

  a_up_key_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !up_valid) |-> (up_key == '0))
    else $error("up key not zero without an up entry");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (depth_now <= HISTORY_DEPTH))
    else $error("depth beyond capacity");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted beat gave neither result nor busy");

  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy && status == ST_POPPED))
    else $error("fetch did not finish with a pop result");

endmodule

bind bounded_navigation_history_stack_unit bnhs_chk #(
  .HISTORY_DEPTH (HISTORY_DEPTH),
  .KEY_BITS      (KEY_BITS)
) u_bnhs_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .depth_now (depth_now),
  .up_valid  (up_valid),
  .up_key    (up_key)
);

// ===== dv/bounded_navigation_history_stack_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_navigation_history_stack_unit_tb
// Self-checking bench for the bounded navigation history stack unit.
// ----------------------------------------------------------------------------
// A queue of commands feeds a driver. The commands are a directed opening
// that covers the corner cases, then random runs that draw keys from small
// pools and often aim up and replace commands at the live up entry. Each
// accepted beat is run through a local model of the stack. Its report is
// queued and compared field by field against the result strobed on done.
// The sender idles at three different rates and sometimes waits for the
// unit to drain.
// ----------------------------------------------------------------------------
module bounded_navigation_history_stack_unit_tb;
  import bnhs_pkg::*;

  localparam int DEPTH       = 16;
  localparam int KW          = 32;
  localparam int RAND_ITEMS  = 1000;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    action_t         act;
    logic [KW-1:0]   key;
    bit              aim_up;
    bit              drain_first;
  } nav_cmd_t;

  typedef struct {
    status_t         status;
    logic [4:0]      depth;
    logic            up_valid;
    logic [KW-1:0]   up_key;
  } nav_report_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action;
  logic [KW-1:0]       key;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [4:0]          depth_now;
  logic                up_valid;
  logic [KW-1:0]       up_key;

  nav_cmd_t    cmd_queue[$];
  nav_report_t report_queue[$];
  logic [KW-1:0] hist_keys [DEPTH];
  int          hist_fill;
  bit          beat_taken;
  int          issued_count;
  int          cycle_count;
  int          mismatch_count;

  bounded_navigation_history_stack_unit #(
    .HISTORY_DEPTH(DEPTH),
    .KEY_BITS(KW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .key(key),
    .done(done),
    .status(status),
    .depth_now(depth_now),
    .up_valid(up_valid),
    .up_key(up_key)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void hist_push(logic [KW-1:0] k);
    if (hist_fill > 0 && hist_keys[hist_fill-1] == k) return;
    if (hist_fill >= DEPTH) begin
      for (int i = 1; i < DEPTH; i++) hist_keys[i-1] = hist_keys[i];
      hist_fill = DEPTH - 1;
    end
    hist_keys[hist_fill] = k;
    hist_fill++;
  endfunction

  function automatic nav_report_t nav_apply(action_t act, logic [KW-1:0] k);
    nav_report_t r;
    action_t     a;
    r.status = ST_DONE;
    a = act;
    if (a == ACT_UP && hist_fill < 2) a = ACT_REPL_ALL;
    case (a)
      ACT_UP: begin
        if (hist_keys[hist_fill-2] != k) begin
          r.status = ST_REJECTED;
        end else begin
          hist_fill--;
          r.status = ST_POPPED;
        end
      end
      ACT_DOWN: hist_push(k);
      ACT_REPL_CUR: begin
        if (hist_fill == 0) begin
          hist_push(k);
        end else if (hist_fill > 1 && hist_keys[hist_fill-2] == k) begin
          hist_fill--;
          r.status = ST_POPPED;
        end else begin
          hist_keys[hist_fill-1] = k;
        end
      end
      ACT_REPL_ALL: begin
        hist_fill = 0;
        hist_push(k);
      end
      ACT_CLEAR: hist_fill = 0;
      default: r.status = ST_REJECTED;
    endcase
    r.depth    = 5'(hist_fill);
    r.up_valid = (hist_fill >= 2);
    r.up_key   = (hist_fill >= 2) ? hist_keys[hist_fill-2] : '0;
    return r;
  endfunction

  function automatic void add_cmd(action_t act, logic [KW-1:0] k, bit aim, bit drain);
    nav_cmd_t c;
    c.act         = act;
    c.key         = k;
    c.aim_up      = aim;
    c.drain_first = drain;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [KW-1:0] pool_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // driver: one beat in flight at most, start held until taken
  always @(negedge clk) begin
    nav_cmd_t c;
    logic     next_start;
    int       idle_pct;
    if (!rst) begin
      next_start = start && !beat_taken;
      beat_taken = 1'b0;
      idle_pct = (issued_count < 340) ? 28 : (issued_count < 680) ? 72 : 0;
      if (!next_start && cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        c = cmd_queue[0];
        if (!c.drain_first || report_queue.size() == 0) begin
          void'(cmd_queue.pop_front());
          action <= c.act;
          key <= (c.aim_up && hist_fill >= 2) ? hist_keys[hist_fill-2] : c.key;
          next_start = 1'b1;
          issued_count++;
        end
      end
      start <= next_start;
    end
  end

  // monitor: check results, predict accepted beats
  always @(posedge clk) begin
    nav_report_t exp_r;
    if (!rst) begin
      cycle_count++;
      if (done) begin
        if (report_queue.size() == 0) begin
          $error("result with no beat outstanding");
          mismatch_count++;
        end else begin
          exp_r = report_queue.pop_front();
          if (status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status);
            mismatch_count++;
          end
          if (depth_now !== exp_r.depth) begin
            $error("depth_now expected %0d actual %0d", exp_r.depth, depth_now);
            mismatch_count++;
          end
          if (up_valid !== exp_r.up_valid) begin
            $error("up_valid expected %0d actual %0d", exp_r.up_valid, up_valid);
            mismatch_count++;
          end
          if (up_key !== exp_r.up_key) begin
            $error("up_key expected %h actual %h", exp_r.up_key, up_key);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        report_queue.push_back(nav_apply(action_t'(action), key));
        beat_taken = 1'b1;
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int      seg_len;
    int      pool_n;
    int      pick;
    int      made;
    logic [KW-1:0] pool [6];
    logic [KW-1:0] k;
    action_t act;

    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_UP;
    key            = '0;
    hist_fill      = 0;
    beat_taken     = 1'b0;
    issued_count   = 0;
    cycle_count    = 0;
    mismatch_count = 0;

    // directed opening
    add_cmd(ACT_CLEAR,    32'h0,        1'b0, 1'b0);
    add_cmd(ACT_UP,       32'h0,        1'b0, 1'b0); // empty stack, acts as replace-all
    add_cmd(ACT_DOWN,     32'hFFFFFFFF, 1'b0, 1'b0);
    add_cmd(ACT_DOWN,     32'hFFFFFFFF, 1'b0, 1'b0); // same as top, no push
    add_cmd(ACT_UP,       32'h12345678, 1'b0, 1'b0); // wrong key, rejected
    add_cmd(ACT_UP,       32'h0,        1'b0, 1'b0); // pop
    add_cmd(ACT_UP,       32'h00000005, 1'b0, 1'b0); // single entry, acts as replace-all
    add_cmd(ACT_CLEAR,    32'hDEADBEEF, 1'b0, 1'b0);
    add_cmd(ACT_REPL_CUR, 32'hA5A5A5A5, 1'b0, 1'b0); // empty stack, push
    add_cmd(ACT_REPL_CUR, 32'h5A5A5A5A, 1'b0, 1'b0); // overwrite top
    add_cmd(ACT_DOWN,     32'h00000001, 1'b0, 1'b0);
    add_cmd(ACT_REPL_CUR, 32'h5A5A5A5A, 1'b0, 1'b0); // matches up entry, pop
    for (int i = 1; i <= DEPTH; i++) add_cmd(ACT_DOWN, KW'(i), 1'b0, 1'b0); // last overflows

    // random runs with small key pools
    made = 0;
    while (made < RAND_ITEMS) begin
      seg_len = $urandom_range(15, 45);
      pool_n  = $urandom_range(2, 6);
      for (int i = 0; i < pool_n; i++) pool[i] = pool_key();
      for (int i = 0; i < seg_len && made < RAND_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_DOWN;
        else if (pick < 67) act = ACT_UP;
        else if (pick < 86) act = ACT_REPL_CUR;
        else if (pick < 93) act = ACT_REPL_ALL;
        else                act = ACT_CLEAR;
        k = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, pool_n-1)];
        add_cmd(act, k,
                (act == ACT_UP && $urandom_range(0, 9) < 7) ||
                (act == ACT_REPL_CUR && $urandom_range(0, 9) < 3),
                (made % 150) == 0);
        made++;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || start || report_queue.size() > 0) @(negedge clk);
    repeat (5) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
